// ===== hw/rtl/cr_pkg.sv =====
// Package for the complex reciprocal pipeline: fixed-point formats, derived
// widths, status codes and the divider stage record.
// No dependencies.
`default_nettype none

package cr_pkg;

  // Fixed-point format of every input and result part
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Squared magnitude, kept at full width
  localparam int SQ_WIDTH   = 2 * DATA_WIDTH;
  // Dividend: operand magnitude scaled by 2^(2*FRAC_BITS)
  localparam int NUM_WIDTH  = DATA_WIDTH + 2 * FRAC_BITS;
  // Dividend bits above the quotient window
  localparam int HI_WIDTH   = NUM_WIDTH - DATA_WIDTH;
  // Partial remainder, one spare bit for the shift before compare
  localparam int REM_WIDTH  = ((SQ_WIDTH > HI_WIDTH) ? SQ_WIDTH : HI_WIDTH) + 1;

  // Stream payload: two parts packed, padded to whole bytes
  localparam int TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  // One item as it moves through the restoring divider stages.
  // lo starts as the low dividend bits and fills with quotient bits.
  typedef struct packed {
    logic [SQ_WIDTH-1:0]   sq;
    logic [REM_WIDTH-1:0]  rem_re;
    logic [REM_WIDTH-1:0]  rem_im;
    logic [DATA_WIDTH-1:0] lo_re;
    logic [DATA_WIDTH-1:0] lo_im;
    logic                  ovf_re;
    logic                  ovf_im;
    logic                  neg_re;
    logic                  neg_im;
    logic                  zero;
  } div_t;

endpackage

`default_nettype wire

// ===== hw/rtl/complex_reciprocal.sv =====
// Complex reciprocal 1/z = (a - bi)/(a*a + b*b) in signed fixed point, one item per cycle.
// Depends on cr_pkg (formats, status codes, divider stage record).
//
//   channel   direction  payload
//   s_*       in         tdata: z_real, z_imag
//   m_*       out        tdata: recip_real, recip_imag; tuser: status
//
// Stages in order: magnitude, square, sum, range check, one restoring divide
// step per quotient bit, then saturation, sign and status. A new transfer is
// taken every cycle while no untaken result holds the output; throughput is set
// by nothing but the output handshake. All stages advance together; when the output
// register holds an untaken result, the whole pipe holds. Reset clears the
// valid bits only.
`default_nettype none

module complex_reciprocal (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  input  wire logic [cr_pkg::TDATA_WIDTH-1:0] s_tdata,   // z_real, z_imag
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  output      logic [cr_pkg::TDATA_WIDTH-1:0] m_tdata,   // recip_real, recip_imag
  output      cr_pkg::status_t                m_tuser    // status
);
  import cr_pkg::*;

  localparam logic [DATA_WIDTH-1:0] HALF = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MAXP = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic en;

  // Whole pipe moves unless a result waits at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- stage 1: magnitudes and signs
  logic [DATA_WIDTH-1:0] z_real, z_imag;
  logic                  v1;
  logic [DATA_WIDTH-1:0] mag_re1, mag_im1;
  logic                  neg_re1, neg_im1, zero1;

  assign z_real = s_tdata[DATA_WIDTH-1:0];
  assign z_imag = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_re1 <= z_real[DATA_WIDTH-1] ? (~z_real + 1'b1) : z_real;
      mag_im1 <= z_imag[DATA_WIDTH-1] ? (~z_imag + 1'b1) : z_imag;
      // Real part keeps its sign, imaginary part is negated
      neg_re1 <= z_real[DATA_WIDTH-1];
      neg_im1 <= !z_imag[DATA_WIDTH-1] && (z_imag != '0);
      zero1   <= (z_real == '0) && (z_imag == '0);
    end
  end

  // ---------------- stage 2: squares
  logic                  v2;
  logic [SQ_WIDTH-1:0]   sq_re2, sq_im2;
  logic [DATA_WIDTH-1:0] mag_re2, mag_im2;
  logic                  neg_re2, neg_im2, zero2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_re2  <= SQ_WIDTH'(mag_re1) * SQ_WIDTH'(mag_re1);
      sq_im2  <= SQ_WIDTH'(mag_im1) * SQ_WIDTH'(mag_im1);
      mag_re2 <= mag_re1;
      mag_im2 <= mag_im1;
      neg_re2 <= neg_re1;
      neg_im2 <= neg_im1;
      zero2   <= zero1;
    end
  end

  // ---------------- stage 3: squared magnitude
  logic                  v3;
  logic [SQ_WIDTH-1:0]   sq3;
  logic [DATA_WIDTH-1:0] mag_re3, mag_im3;
  logic                  neg_re3, neg_im3, zero3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq3     <= sq_re2 + sq_im2;
      mag_re3 <= mag_re2;
      mag_im3 <= mag_im2;
      neg_re3 <= neg_re2;
      neg_im3 <= neg_im2;
      zero3   <= zero2;
    end
  end

  // ---------------- stage 4: split dividends, quotient range check
  logic [NUM_WIDTH-1:0] num_re, num_im;
  logic [REM_WIDTH-1:0] hi_re, hi_im, sq_ext3;

  assign num_re  = {mag_re3, {(2*FRAC_BITS){1'b0}}};
  assign num_im  = {mag_im3, {(2*FRAC_BITS){1'b0}}};
  assign hi_re   = REM_WIDTH'(num_re[NUM_WIDTH-1:DATA_WIDTH]);
  assign hi_im   = REM_WIDTH'(num_im[NUM_WIDTH-1:DATA_WIDTH]);
  assign sq_ext3 = REM_WIDTH'(sq3);

  logic div_v [0:DATA_WIDTH];
  div_t div_q [0:DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_v[0] <= 1'b0;
    end else if (en) begin
      div_v[0] <= v3;
    end
  end

  // Quotient reaches 2^DATA_WIDTH when the high dividend is not below sq
  always_ff @(posedge clk) begin
    if (en) begin
      div_q[0].sq     <= sq3;
      div_q[0].rem_re <= hi_re;
      div_q[0].rem_im <= hi_im;
      div_q[0].lo_re  <= num_re[DATA_WIDTH-1:0];
      div_q[0].lo_im  <= num_im[DATA_WIDTH-1:0];
      div_q[0].ovf_re <= hi_re >= sq_ext3;
      div_q[0].ovf_im <= hi_im >= sq_ext3;
      div_q[0].neg_re <= neg_re3;
      div_q[0].neg_im <= neg_im3;
      div_q[0].zero   <= zero3;
    end
  end

  // ---------------- divider: one restoring step per stage, both parts
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_div
    logic [REM_WIDTH-1:0] sh_re, sh_im, sq_ext;
    logic                 ge_re, ge_im;
    div_t                 step;

    always_comb begin
      sq_ext = REM_WIDTH'(div_q[k].sq);
      sh_re  = {div_q[k].rem_re[REM_WIDTH-2:0], div_q[k].lo_re[DATA_WIDTH-1]};
      sh_im  = {div_q[k].rem_im[REM_WIDTH-2:0], div_q[k].lo_im[DATA_WIDTH-1]};
      ge_re  = sh_re >= sq_ext;
      ge_im  = sh_im >= sq_ext;
      step        = div_q[k];
      step.rem_re = ge_re ? (sh_re - sq_ext) : sh_re;
      step.rem_im = ge_im ? (sh_im - sq_ext) : sh_im;
      step.lo_re  = {div_q[k].lo_re[DATA_WIDTH-2:0], ge_re};
      step.lo_im  = {div_q[k].lo_im[DATA_WIDTH-2:0], ge_im};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_v[k+1] <= 1'b0;
      end else if (en) begin
        div_v[k+1] <= div_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_q[k+1] <= step;
      end
    end
  end

  // ---------------- output: saturate, apply sign, status
  div_t                  fin;
  logic [DATA_WIDTH-1:0] lim_re, lim_im, val_re, val_im, res_re, res_im;
  logic                  sat_re, sat_im;
  status_t               st;

  always_comb begin
    fin    = div_q[DATA_WIDTH];
    lim_re = fin.neg_re ? HALF : MAXP;
    lim_im = fin.neg_im ? HALF : MAXP;
    sat_re = fin.ovf_re || (fin.lo_re > lim_re);
    sat_im = fin.ovf_im || (fin.lo_im > lim_im);
    val_re = sat_re ? lim_re : fin.lo_re;
    val_im = sat_im ? lim_im : fin.lo_im;
    res_re = fin.neg_re ? (~val_re + 1'b1) : val_re;
    res_im = fin.neg_im ? (~val_im + 1'b1) : val_im;
    st     = (sat_re || sat_im) ? ST_SAT : ST_OK;
    if (fin.zero) begin
      res_re = '0;
      res_im = '0;
      st     = ST_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= div_v[DATA_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= TDATA_WIDTH'({res_im, res_re});
      m_tuser <= st;
    end
  end

  // ---------------- checks
  // A zero input yields zero parts
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_ZERO)) |-> (m_tdata == '0))
    else $error("zero status with nonzero result");

  // A saturated result carries at least one extreme part
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_SAT)) |->
      ((m_tdata[DATA_WIDTH-1:0] == MAXP) || (m_tdata[DATA_WIDTH-1:0] == HALF) ||
       (m_tdata[2*DATA_WIDTH-1:DATA_WIDTH] == MAXP) ||
       (m_tdata[2*DATA_WIDTH-1:DATA_WIDTH] == HALF)))
    else $error("saturated status without an extreme part");

  // Remainder is below the divisor at the divider output when the part did not overflow
  a_rem_re: assert property (@(posedge clk) disable iff (rst)
    (div_v[DATA_WIDTH] && !div_q[DATA_WIDTH].zero && !div_q[DATA_WIDTH].ovf_re) |->
      (div_q[DATA_WIDTH].rem_re < REM_WIDTH'(div_q[DATA_WIDTH].sq)))
    else $error("real remainder not below divisor");

  a_rem_im: assert property (@(posedge clk) disable iff (rst)
    (div_v[DATA_WIDTH] && !div_q[DATA_WIDTH].zero && !div_q[DATA_WIDTH].ovf_im) |->
      (div_q[DATA_WIDTH].rem_im < REM_WIDTH'(div_q[DATA_WIDTH].sq)))
    else $error("imaginary remainder not below divisor");

endmodule

`default_nettype wire

// ===== verif/complex_reciprocal_chk.sv =====
// Checker for the complex reciprocal stream: predicts 1/z for each input transfer
// and compares every output transfer against the oldest pending prediction.
// Depends on cr_pkg (widths, status codes).
`default_nettype none

module complex_reciprocal_chk (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [cr_pkg::TDATA_WIDTH-1:0] s_tdata,   // z_real, z_imag
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [cr_pkg::TDATA_WIDTH-1:0] m_tdata,   // recip_real, recip_imag
  input  wire cr_pkg::status_t                m_tuser,   // status
  output int                                  errors,
  output int                                  pending
);

  import cr_pkg::*;

  localparam int DW = DATA_WIDTH;

  typedef struct {
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    status_t       st;
  } recip_t;

  recip_t recip_q[$];

  // One part of the reciprocal: sign * mag * 2^(2F) / sq, truncated, saturated
  function automatic logic [DW-1:0] scale_part(input logic [DW-1:0] mag, input bit neg,
                                               input logic [127:0] sq, output bit ovf);
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] limit;
    num   = 128'(mag) << (2 * FRAC_BITS);
    quo   = num / sq;
    limit = (128'(1) << (DW - 1)) - (neg ? 128'(0) : 128'(1));
    ovf   = 1'b0;
    if (quo > limit) begin
      ovf = 1'b1;
      quo = limit;
    end
    return neg ? -quo[DW-1:0] : quo[DW-1:0];
  endfunction

  function automatic recip_t predict_recip(input logic [DW-1:0] a, input logic [DW-1:0] b);
    recip_t        r;
    logic [DW-1:0] a_mag;
    logic [DW-1:0] b_mag;
    logic [127:0]  sq;
    bit            ovf_re;
    bit            ovf_im;
    a_mag = a[DW-1] ? -a : a;
    b_mag = b[DW-1] ? -b : b;
    if (a_mag == '0 && b_mag == '0) begin
      r.re = '0;
      r.im = '0;
      r.st = ST_ZERO;
      return r;
    end
    sq   = 128'(a_mag) * 128'(a_mag) + 128'(b_mag) * 128'(b_mag);
    // real keeps the sign of a, imaginary takes the opposite sign of b
    r.re = scale_part(a_mag, a[DW-1], sq, ovf_re);
    r.im = scale_part(b_mag, !b[DW-1] && b_mag != '0, sq, ovf_im);
    r.st = (ovf_re || ovf_im) ? ST_SAT : ST_OK;
    return r;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Compare output transfers first, then record the new prediction
  always @(posedge clk) begin
    recip_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (recip_q.size() == 0) begin
          $display("%0t: result with none pending: re %h im %h status %0d",
                   $time, m_tdata[DW-1:0], m_tdata[2*DW-1:DW], m_tuser);
          errors++;
        end else begin
          want = recip_q.pop_front();
          if (m_tdata[DW-1:0] !== want.re) begin
            $display("%0t: recip_real expected %h actual %h",
                     $time, want.re, m_tdata[DW-1:0]);
            errors++;
          end
          if (m_tdata[2*DW-1:DW] !== want.im) begin
            $display("%0t: recip_imag expected %h actual %h",
                     $time, want.im, m_tdata[2*DW-1:DW]);
            errors++;
          end
          if (m_tuser !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, m_tuser);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        recip_q.push_back(predict_recip(s_tdata[DW-1:0], s_tdata[2*DW-1:DW]));
    end
    pending <= recip_q.size();
  end

endmodule

`default_nettype wire

// ===== verif/tb_complex_reciprocal.sv =====
// Testbench top for complex_reciprocal: clock, reset, input and output stream
// drivers with random idling, watchdog and verdict.
// Depends on cr_pkg, complex_reciprocal and complex_reciprocal_chk.
`default_nettype none

module tb_complex_reciprocal;

  import cr_pkg::*;

  localparam int DW         = DATA_WIDTH;
  localparam int N_RANDOM   = 1350;
  localparam int QUIET_MAX  = 2000;
  localparam int LONG_HOLD  = 150;
  localparam int DRAIN_WAIT = 2 * (DATA_WIDTH + 5);

  localparam logic [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ONE_V = DW'(1) << FRAC_BITS;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [TDATA_WIDTH-1:0] s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [TDATA_WIDTH-1:0] m_tdata;
  status_t                m_tuser;
  int                     errors;
  int                     pending;
  int                     quiet;
  bit                     send_burst;

  complex_reciprocal uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  complex_reciprocal_chk chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: cycles in a row with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [TDATA_WIDTH-1:0] pack_z(input logic [DW-1:0] re,
                                                    input logic [DW-1:0] im);
    logic [TDATA_WIDTH-1:0] w;
    w = '0;
    w[DW-1:0]    = re;
    w[2*DW-1:DW] = im;
    return w;
  endfunction

  // Random part value: mix of full range, tiny, near one, zero and extremes
  function automatic logic [DW-1:0] draw_part();
    logic [DW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = DW'({$urandom(), $urandom()});
      3, 4:    v = DW'($urandom_range(1, 300));
      5, 6:    v = ONE_V + DW'($urandom_range(0, 1 << FRAC_BITS)) - (ONE_V >> 1);
      7:       v = '0;
      8:       v = $urandom_range(0, 1) ? MAX_V : MIN_V;
      default: v = DW'($urandom()) >> $urandom_range(0, DW - 1);
    endcase
    if ($urandom_range(0, 1))
      v = -v;
    return v;
  endfunction

  // Offer one z, wait for its transfer; returns at the following falling edge
  task automatic send_z(input logic [DW-1:0] re, input logic [DW-1:0] im);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_z(re, im);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Output side: random stalls, stall-free stretches, one long hold-off
  initial begin
    int stall;
    int taken;
    bit no_stall;
    m_tready = 1'b0;
    taken    = 0;
    no_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 128 == 0)
        no_stall = ($urandom_range(0, 3) == 0);
      stall = no_stall ? 0 : $urandom_range(0, 5);
      if (taken == 300)
        stall = LONG_HOLD;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // Input side: directed corners, then random items, then drain and verdict
  initial begin
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    send_burst = 1'b0;
    rst        = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero input, tiny parts that saturate or land exactly on the minimum
    send_z('0, '0);
    send_z(DW'(1), '0);
    send_z('0, DW'(1));
    send_z(-DW'(1), '0);
    send_z('0, -DW'(1));
    send_z(DW'(2), '0);
    send_z(-DW'(2), '0);
    send_z('0, DW'(2));
    send_z('0, -DW'(2));
    // extremes of both fields
    send_z(MAX_V, MAX_V);
    send_z(MIN_V, MIN_V);
    send_z(MIN_V, '0);
    send_z('0, MIN_V);
    send_z(MAX_V, '0);
    send_z(MIN_V, MAX_V);
    send_z(MAX_V, MIN_V);
    // ordinary values around one
    send_z(ONE_V, '0);
    send_z('0, ONE_V);
    send_z(-ONE_V, ONE_V);
    send_z(ONE_V >> 1, '0);
    send_z(DW'(2) * ONE_V, DW'(3) * ONE_V);
    send_z(DW'(1), ONE_V);
    send_z(DW'(256), '0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0)
        send_burst = ($urandom_range(0, 3) == 0);
      send_z(draw_part(), draw_part());
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/cr_pkg.sv
hw/rtl/complex_reciprocal.sv
verif/complex_reciprocal_chk.sv
verif/tb_complex_reciprocal.sv
